/* design/lsr_pkg.sv */
// shared constants, item types and corner coefficient function for the stencil residual block
package lsr_pkg;

  // lattice geometry
  localparam int SIDE       = 256;
  localparam int KD         = 0;
  localparam int HALF       = SIDE / 2;
  localparam int LINE       = SIDE + 1;
  localparam int LINE_DEPTH = 2 * LINE;
  localparam int DELAY      = SIDE + 2;
  localparam int CNT_W      = $clog2(SIDE + 1);
  localparam int LADDR_W    = $clog2(LINE_DEPTH);
  localparam int RADDR_W    = $clog2(DELAY);

  // datapath widths
  localparam int WORD_W  = 32;
  localparam int NCMP    = 3;
  localparam int NCRN    = 4;
  localparam int IDX_W   = 8;
  localparam int CRD_W   = CNT_W + 1;
  localparam int SQ_W    = 2 * CRD_W;
  localparam int COEF_W  = 2 * CRD_W;
  localparam int DIAG_K  = 2 * (2 + KD);
  localparam int SK_W    = SQ_W + 3;
  localparam int PROD_W  = COEF_W + WORD_W;
  localparam int ACC_W   = PROD_W + 5;
  localparam int HI_W    = ACC_W - WORD_W;
  localparam int HP_W    = HI_W + WORD_W + 1;
  localparam int RES_W   = HP_W + 3;

  localparam logic [WORD_W-1:0] HSTEP_RESET = 32'd214748;

  // corner offsets in row and column, ordered as the corner index
  localparam logic signed [1:0] QX [NCRN] = '{-2'sd1, -2'sd1, 2'sd1, 2'sd1};
  localparam logic signed [1:0] QY [NCRN] = '{-2'sd1, 2'sd1, -2'sd1, 2'sd1};

  typedef logic [NCMP-1:0][WORD_W-1:0] vec3_t;
  typedef logic [NCMP-1:0][NCMP-1:0][COEF_W-1:0] coef_mat_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] u_a;
    logic signed [WORD_W-1:0] u_b;
    logic signed [WORD_W-1:0] u_c;
    logic signed [WORD_W-1:0] rhs_a;
    logic signed [WORD_W-1:0] rhs_b;
    logic signed [WORD_W-1:0] rhs_c;
  } pt_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] res_a;
    logic signed [WORD_W-1:0] res_b;
    logic signed [WORD_W-1:0] res_c;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic                     frame_last;
  } res_t;

  // front end to window: new column of the window plus delayed rhs
  typedef struct packed {
    vec3_t            u;
    vec3_t            old_u;
    vec3_t            mid_u;
    vec3_t            fd;
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
    logic             prod;
    logic             last;
  } fr_t;

  // window to arithmetic: corner values, coefficients and centre data
  typedef struct packed {
    coef_mat_t [NCRN-1:0] cf;
    vec3_t [NCRN-1:0]     cu;
    vec3_t                uc;
    vec3_t                fd;
    logic [SK_W-1:0]      sk;
    logic [IDX_W-1:0]     row_index;
    logic [IDX_W-1:0]     col_index;
    logic                 last;
  } w2_t;

  // corner coupling polynomials for offset (qx,qy) at centred coordinates (x,y)
  function automatic coef_mat_t corner_poly(input logic signed [1:0] qx,
                                            input logic signed [1:0] qy,
                                            input logic signed [CRD_W-1:0] x,
                                            input logic signed [CRD_W-1:0] y);
    logic signed [COEF_W-1:0] sx, sy, xw, yw, d, a, b, s, c, one, two;
    coef_mat_t p;
    sx  = COEF_W'(qx);
    sy  = COEF_W'(qy);
    xw  = COEF_W'(x);
    yw  = COEF_W'(y);
    one = COEF_W'(1);
    two = COEF_W'(2);
    d   = -(sx * sy);
    a   = yw * d + xw;
    b   = yw + xw * d;
    s   = xw * xw + yw * yw;
    c   = two * sx * sy * xw * yw;
    p[0][0] = one - two * sx * a + s - c;
    p[0][1] = two * sx * sy - two * sy * a;
    p[0][2] = one;
    p[1][0] = d - sx * b;
    p[1][1] = -two - sx * a - sy * b + s - c;
    p[1][2] = d - sy * a;
    p[2][0] = one;
    p[2][1] = two * sx * sy - two * sx * b;
    p[2][2] = one - two * sy * b + s - c;
    return p;
  endfunction

endpackage

/* design/lsr_front.sv */
// raster counters, padding, field line store and rhs delay store
module lsr_front import lsr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic pt_valid,
  output logic pt_stall,
  input  pt_t  pt,
  output logic fr_valid,
  input  logic fr_ready,
  output fr_t  fr
);

  // line store holds two rows of field values, rhs store is a fixed delay line
  vec3_t line_mem [LINE_DEPTH];
  vec3_t rhs_mem [DELAY];

  logic [CNT_W-1:0]   rcnt, ccnt;
  logic [RADDR_W-1:0] rptr;
  logic               s1v;
  logic               ld1, acc, pad;
  vec3_t              u_pad, f_pad;
  logic [LADDR_W-1:0] slot_old, slot_mid;

  vec3_t            u_q, old_q, mid_q, fd_q;
  logic [CNT_W-1:0] row_q, col_q;
  logic             prod_q, last_q;

  // handshake
  assign ld1      = !s1v || fr_ready;
  assign pt_stall = !ld1;
  assign acc      = pt_valid && ld1;

  // padding row and column read as zero
  assign pad   = (rcnt == CNT_W'(SIDE)) || (ccnt == CNT_W'(SIDE));
  assign u_pad = pad ? '0 : {pt.u_c, pt.u_b, pt.u_a};
  assign f_pad = pad ? '0 : {pt.rhs_c, pt.rhs_b, pt.rhs_a};

  // bank of row r-2 is the one overwritten by row r
  assign slot_old = LADDR_W'(ccnt) + (rcnt[0] ? LADDR_W'(LINE) : '0);
  assign slot_mid = LADDR_W'(ccnt) + (rcnt[0] ? '0 : LADDR_W'(LINE));

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1v  <= 1'b0;
      rcnt <= '0;
      ccnt <= '0;
      rptr <= '0;
    end else begin
      if (ld1) begin
        s1v <= pt_valid;
      end
      if (acc) begin
        if (ccnt == CNT_W'(SIDE)) begin
          ccnt <= '0;
          rcnt <= (rcnt == CNT_W'(SIDE)) ? '0 : rcnt + 1'b1;
        end else begin
          ccnt <= ccnt + 1'b1;
        end
        rptr <= (rptr == RADDR_W'(DELAY - 1)) ? '0 : rptr + 1'b1;
      end
    end
  end

  // read-before-write stores and stage payload
  always_ff @(posedge clk) begin
    if (acc) begin
      old_q              <= line_mem[slot_old];
      mid_q              <= line_mem[slot_mid];
      line_mem[slot_old] <= u_pad;
      fd_q               <= rhs_mem[rptr];
      rhs_mem[rptr]      <= f_pad;
      u_q                <= u_pad;
      row_q              <= rcnt;
      col_q              <= ccnt;
      prod_q             <= (rcnt >= CNT_W'(2)) && (ccnt >= CNT_W'(2));
      last_q             <= (rcnt == CNT_W'(SIDE)) && (ccnt == CNT_W'(SIDE));
    end
  end

  assign fr_valid  = s1v;
  assign fr.u      = u_q;
  assign fr.old_u  = old_q;
  assign fr.mid_u  = mid_q;
  assign fr.fd     = fd_q;
  assign fr.row    = row_q;
  assign fr.col    = col_q;
  assign fr.prod   = prod_q;
  assign fr.last   = last_q;

endmodule

/* design/lsr_window.sv */
// 3x3 window shift and per-point coefficient generation
module lsr_window import lsr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic fr_valid,
  output logic fr_ready,
  input  fr_t  fr,
  output logic w2_valid,
  input  logic w2_ready,
  output w2_t  w2
);

  // two columns of the window kept; the third comes in with each item
  vec3_t w1 [NCMP];
  vec3_t w2c [NCMP];

  logic                    s2v, ld2, take;
  logic signed [CRD_W-1:0] x, y;
  logic signed [SQ_W-1:0]  xs, ys, s;
  w2_t                     nxt, w2_q;

  assign ld2      = !s2v || w2_ready;
  assign fr_ready = ld2 || !fr.prod;
  assign take     = fr_valid && fr_ready;

  // centred coordinates of the centre point (row-1, col-1)
  assign x  = $signed(CRD_W'(fr.row)) - CRD_W'(HALF + 1);
  assign y  = $signed(CRD_W'(fr.col)) - CRD_W'(HALF + 1);
  assign xs = SQ_W'(x);
  assign ys = SQ_W'(y);
  assign s  = xs * xs + ys * ys;

  // corners and centre of the window after the shift
  always_comb begin
    nxt.cu[0]     = w1[0];
    nxt.cu[1]     = fr.old_u;
    nxt.cu[2]     = w1[2];
    nxt.cu[3]     = fr.u;
    nxt.uc        = w2c[1];
    nxt.fd        = fr.fd;
    nxt.sk        = SK_W'(s) * SK_W'(DIAG_K);
    nxt.row_index = IDX_W'(fr.row - 1'b1);
    nxt.col_index = IDX_W'(fr.col - 1'b1);
    nxt.last      = fr.last;
    for (int q = 0; q < NCRN; q++) begin
      nxt.cf[q] = corner_poly(QX[q], QY[q], x, y);
    end
  end

  // window shift and stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s2v <= 1'b0;
      for (int n = 0; n < NCMP; n++) begin
        w1[n]  <= '0;
        w2c[n] <= '0;
      end
    end else begin
      if (ld2) begin
        s2v <= take && fr.prod;
      end
      if (take) begin
        for (int n = 0; n < NCMP; n++) begin
          w1[n] <= w2c[n];
        end
        w2c[0] <= fr.old_u;
        w2c[1] <= fr.mid_u;
        w2c[2] <= fr.u;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (ld2) begin
      w2_q <= nxt;
    end
  end

  assign w2_valid = s2v;
  assign w2       = w2_q;

endmodule

/* design/lsr_arith.sv */
// products, sums, half-step scaling, residual and saturation
module lsr_arith import lsr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [WORD_W-1:0] half_step,
  input  logic              w2_valid,
  output logic              w2_ready,
  input  w2_t               w2,
  output logic              res_valid,
  input  logic              res_stall,
  output res_t              res
);

  typedef struct packed {
    logic [WORD_W-1:0] uc0, uc1, uc2;
    vec3_t             fd;
    logic [IDX_W-1:0]  row_index;
    logic [IDX_W-1:0]  col_index;
    logic              last;
  } side_t;

  localparam logic signed [RES_W-1:0] SAT_HI = RES_W'(2147483647);
  localparam logic signed [RES_W-1:0] SAT_LO = -SAT_HI - 1'b1;

  logic v3, v4, v5, v6, v7;
  logic ld3, ld4, ld5, ld6, ld7;

  side_t sd2, sd3, sd4, sd5, sd6;
  logic signed [PROD_W-1:0] prod [NCMP][NCRN][NCMP];
  logic signed [ACC_W-1:0]  dp3 [NCMP];
  logic signed [ACC_W-1:0]  part [NCMP][NCRN];
  logic signed [ACC_W-1:0]  dp4 [NCMP];
  logic signed [ACC_W-1:0]  nsum [NCMP];
  logic signed [ACC_W-1:0]  dp5 [NCMP];
  logic [2*WORD_W-1:0]      lo_n [NCMP];
  logic [2*WORD_W-1:0]      lo_d [NCMP];
  logic signed [HP_W-1:0]   hi_n [NCMP];
  logic signed [HP_W-1:0]   hi_d [NCMP];
  logic signed [RES_W-1:0]  tot [NCMP];
  logic [WORD_W-1:0]        sat [NCMP];
  res_t                     res_q;

  // elastic chain: a stage loads when empty or when the next one loads
  assign ld7      = !v7 || !res_stall;
  assign ld6      = !v6 || ld7;
  assign ld5      = !v5 || ld6;
  assign ld4      = !v4 || ld5;
  assign ld3      = !v3 || ld4;
  assign w2_ready = ld3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (ld3) v3 <= w2_valid;
      if (ld4) v4 <= v3;
      if (ld5) v5 <= v4;
      if (ld6) v6 <= v5;
      if (ld7) v7 <= v6;
    end
  end

  assign sd2.uc0       = w2.uc[0];
  assign sd2.uc1       = w2.uc[1];
  assign sd2.uc2       = w2.uc[2];
  assign sd2.fd        = w2.fd;
  assign sd2.row_index = w2.row_index;
  assign sd2.col_index = w2.col_index;
  assign sd2.last      = w2.last;

  // coefficient times field products, and the diagonal product
  always_ff @(posedge clk) begin
    if (ld3) begin
      sd3 <= sd2;
      for (int i = 0; i < NCMP; i++) begin
        dp3[i] <= ACC_W'($signed({1'b0, w2.sk})) * ACC_W'($signed(w2.uc[i]));
        for (int q = 0; q < NCRN; q++) begin
          for (int l = 0; l < NCMP; l++) begin
            prod[i][q][l] <= PROD_W'($signed(w2.cf[q][i][l])) *
                             PROD_W'($signed(w2.cu[q][l]));
          end
        end
      end
    end
  end

  // sum over components for each corner
  always_ff @(posedge clk) begin
    if (ld4) begin
      sd4 <= sd3;
      for (int i = 0; i < NCMP; i++) begin
        dp4[i] <= dp3[i];
        for (int q = 0; q < NCRN; q++) begin
          part[i][q] <= ACC_W'(prod[i][q][0]) + ACC_W'(prod[i][q][1]) +
                        ACC_W'(prod[i][q][2]);
        end
      end
    end
  end

  // sum over corners, negated
  always_ff @(posedge clk) begin
    if (ld5) begin
      sd5 <= sd4;
      for (int i = 0; i < NCMP; i++) begin
        dp5[i]  <= dp4[i];
        nsum[i] <= -(part[i][0] + part[i][1] + part[i][2] + part[i][3]);
      end
    end
  end

  // scale by half step as low and high partial products
  always_ff @(posedge clk) begin
    if (ld6) begin
      sd6 <= sd5;
      for (int i = 0; i < NCMP; i++) begin
        lo_n[i] <= (2*WORD_W)'(nsum[i][WORD_W-1:0]) * (2*WORD_W)'(half_step);
        lo_d[i] <= (2*WORD_W)'(dp5[i][WORD_W-1:0]) * (2*WORD_W)'(half_step);
        hi_n[i] <= HP_W'($signed(nsum[i][ACC_W-1:WORD_W])) *
                   HP_W'($signed({1'b0, half_step}));
        hi_d[i] <= HP_W'($signed(dp5[i][ACC_W-1:WORD_W])) *
                   HP_W'($signed({1'b0, half_step}));
      end
    end
  end

  // floor of the scaled terms, residual and saturation
  always_comb begin
    tot[0] = RES_W'($signed(sd6.uc0)) - RES_W'($signed(sd6.fd[0]));
    tot[1] = RES_W'($signed(sd6.uc1)) - RES_W'($signed(sd6.fd[1]));
    tot[2] = RES_W'($signed(sd6.uc2)) - RES_W'($signed(sd6.fd[2]));
    for (int i = 0; i < NCMP; i++) begin
      tot[i] = tot[i] + RES_W'(hi_n[i]) + $signed(RES_W'(lo_n[i][2*WORD_W-1:WORD_W]))
                      + RES_W'(hi_d[i]) + $signed(RES_W'(lo_d[i][2*WORD_W-1:WORD_W]));
      priority if (tot[i] > SAT_HI) begin
        sat[i] = SAT_HI[WORD_W-1:0];
      end else if (tot[i] < SAT_LO) begin
        sat[i] = SAT_LO[WORD_W-1:0];
      end else begin
        sat[i] = tot[i][WORD_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ld7) begin
      res_q.res_a      <= $signed(sat[0]);
      res_q.res_b      <= $signed(sat[1]);
      res_q.res_c      <= $signed(sat[2]);
      res_q.row_index  <= sd6.row_index;
      res_q.col_index  <= sd6.col_index;
      res_q.frame_last <= sd6.last;
    end
  end

  assign res_valid = v7;
  assign res       = res_q;

endmodule

/* design/lattice_stencil_residual.sv */
// Stencil residual block: takes one lattice point per clock in raster order while not
// stalled (rows and columns 0..SIDE, the last row and column being padding) and returns
// one residual item for every point whose row and column are both at least 2, for the
// centre one row and one column back. Sustained rate is one item per cycle while
// res_stall is low; the figure is set by the field line store, which does one
// read-modify-write of a lattice column per cycle. The residual passes seven register
// stages, the first loaded at the edge accepting the item completing its window. A
// frame is (SIDE+1)^2 items and gives (SIDE-1)^2 residuals; no clearing pass is needed
// after reset. The user must write half_step only while idle; the block does not check.
module lattice_stencil_residual import lsr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [WORD_W-1:0] cfg_wdata,
  input  logic              pt_valid,
  output logic              pt_stall,
  input  pt_t               pt,
  output logic              res_valid,
  input  logic              res_stall,
  output res_t              res
);

  logic [WORD_W-1:0] half_step;
  logic              fr_valid, fr_ready, w2_valid, w2_ready;
  fr_t               fr;
  w2_t               w2;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      half_step <= HSTEP_RESET;
    end else if (cfg_we) begin
      half_step <= cfg_wdata;
    end
  end

  lsr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .pt_valid (pt_valid),
    .pt_stall (pt_stall),
    .pt       (pt),
    .fr_valid (fr_valid),
    .fr_ready (fr_ready),
    .fr       (fr)
  );

  lsr_window u_window (
    .clk      (clk),
    .rst      (rst),
    .fr_valid (fr_valid),
    .fr_ready (fr_ready),
    .fr       (fr),
    .w2_valid (w2_valid),
    .w2_ready (w2_ready),
    .w2       (w2)
  );

  lsr_arith u_arith (
    .clk       (clk),
    .rst       (rst),
    .half_step (half_step),
    .w2_valid  (w2_valid),
    .w2_ready  (w2_ready),
    .w2        (w2),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
